@@ hdl/rds_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rds_pkg: shared types and constants of the raycast DDA ray setup block
// Field widths, register indexes and the structures passed between the front
// part, the queue and the back part.
// ----------------------------------------------------------------------------
package rds_pkg;

	localparam int COL_W     = 10;
	localparam int POS_W     = 24;
	localparam int FRAC_W    = 16;
	localparam int CELL_W    = 8;
	localparam int VEC_W     = 16;
	localparam int RAY_W     = 17;
	localparam int MAG_W     = 17;
	localparam int DIST_W    = 32;
	localparam int IDX_W     = 3;
	localparam int QDEPTH    = 8;
	localparam int QPTR_W    = 3;
	localparam int QCNT_W    = 4;
	localparam int DIV_STEPS = 32;

	localparam logic [IDX_W-1:0] REG_POS_X   = 3'd0;
	localparam logic [IDX_W-1:0] REG_POS_Y   = 3'd1;
	localparam logic [IDX_W-1:0] REG_DIR_X   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DIR_Y   = 3'd3;
	localparam logic [IDX_W-1:0] REG_PLANE_X = 3'd4;
	localparam logic [IDX_W-1:0] REG_PLANE_Y = 3'd5;

	typedef struct packed {
		logic [POS_W-1:0]        pos_x;
		logic [POS_W-1:0]        pos_y;
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] plane_x;
		logic signed [VEC_W-1:0] plane_y;
	} rds_cfg_t;

	typedef struct packed {
		logic signed [RAY_W-1:0] ray;
		logic                    zero;
		logic                    neg;
		logic [MAG_W-1:0]        mag;
	} rds_axis_t;

	typedef struct packed {
		rds_axis_t x;
		rds_axis_t y;
	} rds_entry_t;

endpackage
`default_nettype wire

@@ hdl/rds_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rds_front: ray direction front part
// Accepts a column word, forms the ray direction per axis over four stages
// and classifies it (zero, sign, magnitude) before pushing it to the queue.
// ----------------------------------------------------------------------------
module rds_front #(
	parameter int SCREEN_WIDTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rds_pkg::rds_cfg_t           cfg,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rds_pkg::COL_W-1:0]   column,
	input  logic                        pop,
	output logic                        push,
	output rds_pkg::rds_entry_t         push_data
);
	import rds_pkg::*;

	localparam int OFFS_W = (($clog2(SCREEN_WIDTH + 1) > COL_W + 1) ?
		$clog2(SCREEN_WIDTH + 1) : COL_W + 1) + 1;
	localparam int PROD_W = VEC_W + OFFS_W;
	localparam int M_W    = PROD_W;
	localparam int RSH    = M_W + 1;
	localparam int RCP_W  = RSH - 1;
	localparam int SUM_W  = M_W + 2;
	localparam longint RECIP = (longint'(1) << RSH) / (2 * SCREEN_WIDTH);
	localparam logic [RCP_W-1:0] RCP    = RCP_W'(RECIP);
	localparam logic [M_W-1:0]   DIV2_L = M_W'(2 * SCREEN_WIDTH);
	localparam logic [M_W-1:0]   W_L    = M_W'(SCREEN_WIDTH);
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (RAY_W - 1) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (RAY_W - 1)));

	logic                     accept;
	logic [QCNT_W-1:0]        cnt_q;
	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [OFFS_W-1:0] offs;
	logic signed [VEC_W-1:0]  plane [2];
	logic signed [VEC_W-1:0]  dir [2];
	rds_axis_t                ax_s4 [2];

	assign accept   = in_valid && !in_stall;
	// Credits cover the items in the front stages as well as in the queue.
	assign in_stall = (cnt_q == QCNT_W'(QDEPTH));
	assign offs = $signed(OFFS_W'({column, 1'b0})) - $signed(OFFS_W'(SCREEN_WIDTH));
	assign plane[0] = cfg.plane_x;
	assign plane[1] = cfg.plane_y;
	assign dir[0]   = cfg.dir_x;
	assign dir[1]   = cfg.dir_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + QCNT_W'(accept) - QCNT_W'(pop);
			v_s1  <= accept;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_ax
		logic signed [PROD_W-1:0]      n_s1;
		logic [M_W-1:0]                mag_n;
		logic [M_W-1:0]                m_s2, m_s3;
		logic                          neg_s2, neg_s3;
		logic [M_W+RCP_W-1:0]          prod;
		logic [M_W-1:0]                qe_s3;
		logic [M_W-1:0]                r;
		logic [M_W-1:0]                q;
		logic signed [SUM_W-1:0]       term;
		logic signed [SUM_W-1:0]       sum;
		logic signed [RAY_W-1:0]       ray;
		rds_axis_t                     ax;

		assign mag_n = n_s1[PROD_W-1] ? M_W'(-n_s1) : M_W'(n_s1);
		assign prod  = m_s2 * RCP;

		// The reciprocal estimate is at most one below the rounded quotient.
		always_comb begin
			r    = m_s3 - M_W'(qe_s3 * DIV2_L);
			q    = qe_s3 + M_W'(r >= DIV2_L);
			term = neg_s3 ? -$signed({2'b00, q}) : $signed({2'b00, q});
			sum  = SUM_W'(dir[a]) + term;
			if (sum > SAT_HI) begin
				ray = RAY_W'(SAT_HI);
			end else if (sum < SAT_LO) begin
				ray = RAY_W'(SAT_LO);
			end else begin
				ray = RAY_W'(sum);
			end
			ax.ray  = ray;
			ax.zero = (ray == '0);
			ax.neg  = ray[RAY_W-1];
			ax.mag  = ray[RAY_W-1] ? MAG_W'(-ray) : MAG_W'(ray);
		end

		always_ff @(posedge clk) begin
			n_s1     <= plane[a] * offs;
			m_s2     <= (mag_n << 1) + W_L;
			neg_s2   <= n_s1[PROD_W-1];
			m_s3     <= m_s2;
			neg_s3   <= neg_s2;
			qe_s3    <= M_W'(prod[M_W+RCP_W-1:RSH]);
			ax_s4[a] <= ax;
		end
	end

	assign push        = v_s4;
	assign push_data.x = ax_s4[0];
	assign push_data.y = ax_s4[1];

endmodule
`default_nettype wire

@@ hdl/rds_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rds_queue: short queue between the front and back parts
// Holds classified ray words so that each side may stall on its own.
// ----------------------------------------------------------------------------
module rds_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rds_pkg::rds_entry_t push_data,
	input  logic                pop,
	output logic                head_valid,
	output rds_pkg::rds_entry_t head_data
);
	import rds_pkg::*;

	rds_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			cnt_q    <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != QCNT_W'(QDEPTH)) || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

@@ hdl/rds_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rds_back: delta and side distance back part
// A pipelined restoring divider forms 1/|ray| one bit a stage; one multiplier
// stage then forms the side distance ahead of the output register.
// ----------------------------------------------------------------------------
module rds_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rds_pkg::rds_cfg_t                cfg,
	input  logic                             head_valid,
	input  rds_pkg::rds_entry_t              head_data,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [rds_pkg::RAY_W-1:0] ray_dir_x,
	output logic signed [rds_pkg::RAY_W-1:0] ray_dir_y,
	output logic [rds_pkg::CELL_W-1:0]       cell_x,
	output logic [rds_pkg::CELL_W-1:0]       cell_y,
	output logic [rds_pkg::DIST_W-1:0]       delta_dist_x,
	output logic [rds_pkg::DIST_W-1:0]       delta_dist_y,
	output logic                             step_neg_x,
	output logic                             step_neg_y,
	output logic [rds_pkg::DIST_W-1:0]       side_dist_x,
	output logic [rds_pkg::DIST_W-1:0]       side_dist_y
);
	import rds_pkg::*;

	localparam int DVS_W = MAG_W + 1;
	localparam int PRD_W = (FRAC_W + 1) + (DIST_W - 1);

	typedef struct packed {
		logic                    zero;
		logic                    neg;
		logic signed [RAY_W-1:0] ray;
		logic [DVS_W-1:0]        dvs;
		logic [DVS_W-1:0]        rem;
		logic [DIST_W-1:0]       num;
		logic [DIST_W-1:0]       quo;
	} rds_div_t;

	typedef struct packed {
		logic                    zero;
		logic                    neg;
		logic signed [RAY_W-1:0] ray;
		logic [DIST_W-1:0]       delta;
		logic [PRD_W-1:0]        prod;
	} rds_mul_t;

	function automatic rds_div_t div_load(rds_axis_t a);
		rds_div_t d;
		d.zero = a.zero;
		d.neg  = a.neg;
		d.ray  = a.ray;
		d.dvs  = {a.mag, 1'b0};
		d.rem  = '0;
		// Dividend 2^31 + |ray| gives the quotient rounded to nearest.
		d.num  = {1'b1, {(DIST_W - 1){1'b0}}} + DIST_W'(a.mag);
		d.quo  = '0;
		return d;
	endfunction

	function automatic rds_div_t div_step(rds_div_t d);
		rds_div_t   o;
		logic [DVS_W:0] t;
		o     = d;
		t     = {d.rem, d.num[DIST_W-1]};
		o.num = d.num << 1;
		if (t >= {1'b0, d.dvs}) begin
			o.rem = DVS_W'(t - {1'b0, d.dvs});
			o.quo = {d.quo[DIST_W-2:0], 1'b1};
		end else begin
			o.rem = DVS_W'(t);
			o.quo = {d.quo[DIST_W-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic rds_mul_t mul_form(rds_div_t d, logic [FRAC_W-1:0] frac);
		rds_mul_t        m;
		logic [FRAC_W:0] g;
		// Distance to the next grid line in the stepping direction.
		g       = d.neg ? {1'b0, frac} : ({1'b1, {FRAC_W{1'b0}}} - {1'b0, frac});
		m.zero  = d.zero;
		m.neg   = d.neg;
		m.ray   = d.ray;
		m.delta = d.quo;
		m.prod  = g * d.quo[DIST_W-2:0];
		return m;
	endfunction

	logic                 adv;
	logic [DIV_STEPS:0]   vld_s;
	logic                 mul_vld_s;
	logic                 out_valid_q;
	rds_div_t             div_s [DIV_STEPS+1][2];
	rds_mul_t             mul_s [2];
	logic [DIST_W-1:0]    delta_q [2];
	logic [DIST_W-1:0]    side_q [2];
	logic                 neg_q [2];
	logic signed [RAY_W-1:0] ray_q [2];
	logic [FRAC_W-1:0]    frac [2];

	// The whole back pipeline moves together unless a finished word waits.
	assign adv       = !(out_valid_q && out_stall);
	assign pop       = head_valid && adv;
	assign out_valid = out_valid_q;
	assign frac[0]   = cfg.pos_x[FRAC_W-1:0];
	assign frac[1]   = cfg.pos_y[FRAC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			mul_vld_s   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s       <= {vld_s[DIV_STEPS-1:0], head_valid};
			mul_vld_s   <= vld_s[DIV_STEPS];
			out_valid_q <= mul_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0][0] <= div_load(head_data.x);
			div_s[0][1] <= div_load(head_data.y);
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k+1][0] <= div_step(div_s[k][0]);
				div_s[k+1][1] <= div_step(div_s[k][1]);
			end
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_ax
		logic [PRD_W:0]  rnd;
		logic [DIST_W:0] side_w;

		assign rnd    = {1'b0, mul_s[a].prod} + (PRD_W + 1)'(1 << (FRAC_W - 1));
		assign side_w = rnd[PRD_W:FRAC_W];

		always_ff @(posedge clk) begin
			if (adv) begin
				mul_s[a] <= mul_form(div_s[DIV_STEPS][a], frac[a]);
				ray_q[a] <= mul_s[a].ray;
				if (mul_s[a].zero) begin
					delta_q[a] <= '1;
					side_q[a]  <= '1;
					neg_q[a]   <= 1'b0;
				end else begin
					delta_q[a] <= mul_s[a].delta;
					side_q[a]  <= side_w[DIST_W] ? '1 : side_w[DIST_W-1:0];
					neg_q[a]   <= mul_s[a].neg;
				end
			end
		end
	end

	assign ray_dir_x    = ray_q[0];
	assign ray_dir_y    = ray_q[1];
	assign cell_x       = cfg.pos_x[POS_W-1:FRAC_W];
	assign cell_y       = cfg.pos_y[POS_W-1:FRAC_W];
	assign delta_dist_x = delta_q[0];
	assign delta_dist_y = delta_q[1];
	assign step_neg_x   = neg_q[0];
	assign step_neg_y   = neg_q[1];
	assign side_dist_x  = side_q[0];
	assign side_dist_y  = side_q[1];

endmodule
`default_nettype wire

@@ hdl/raycast_dda_setup_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// raycast_dda_setup_top: raycast DDA ray setup for one screen column
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    column
//   output   out        out_valid / out_stall  ray, cell, delta, step, side
//   config   in         cfg_we                 cfg_idx, cfg_data
//
// One column word enters per cycle while in_stall is low. Its result word passes,
// in order, the four ray stages, the queue slot, the divider load and its 32
// steps, the multiplier stage and the output register.
// Reset is asynchronous and restores the default camera registers.
// A stalled output freezes the back part; the queue then fills and in_stall
// rises once eight words are in flight in the front stages and the queue together.
// ----------------------------------------------------------------------------
module raycast_dda_setup_top #(
	parameter int SCREEN_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rds_pkg::IDX_W-1:0]        cfg_idx,
	input  logic [rds_pkg::POS_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rds_pkg::COL_W-1:0]        column,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [rds_pkg::RAY_W-1:0] ray_dir_x,
	output logic signed [rds_pkg::RAY_W-1:0] ray_dir_y,
	output logic [rds_pkg::CELL_W-1:0]       cell_x,
	output logic [rds_pkg::CELL_W-1:0]       cell_y,
	output logic [rds_pkg::DIST_W-1:0]       delta_dist_x,
	output logic [rds_pkg::DIST_W-1:0]       delta_dist_y,
	output logic                             step_neg_x,
	output logic                             step_neg_y,
	output logic [rds_pkg::DIST_W-1:0]       side_dist_x,
	output logic [rds_pkg::DIST_W-1:0]       side_dist_y
);
	import rds_pkg::*;

	rds_cfg_t   cfg_q;
	logic       push, pop, head_valid;
	rds_entry_t push_data, head_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x   <= 24'h800000;
			cfg_q.pos_y   <= 24'h800000;
			cfg_q.dir_x   <= -16'sd16384;
			cfg_q.dir_y   <= 16'sd0;
			cfg_q.plane_x <= 16'sd0;
			cfg_q.plane_y <= 16'sd10813;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_POS_X:   cfg_q.pos_x   <= cfg_data;
				REG_POS_Y:   cfg_q.pos_y   <= cfg_data;
				REG_DIR_X:   cfg_q.dir_x   <= cfg_data[VEC_W-1:0];
				REG_DIR_Y:   cfg_q.dir_y   <= cfg_data[VEC_W-1:0];
				REG_PLANE_X: cfg_q.plane_x <= cfg_data[VEC_W-1:0];
				REG_PLANE_Y: cfg_q.plane_y <= cfg_data[VEC_W-1:0];
				default: ;
			endcase
		end
	end

	rds_front #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.column    (column),
		.pop       (pop),
		.push      (push),
		.push_data (push_data)
	);

	rds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	rds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head_data    (head_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ray_dir_x    (ray_dir_x),
		.ray_dir_y    (ray_dir_y),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.delta_dist_x (delta_dist_x),
		.delta_dist_y (delta_dist_y),
		.step_neg_x   (step_neg_x),
		.step_neg_y   (step_neg_y),
		.side_dist_x  (side_dist_x),
		.side_dist_y  (side_dist_y)
	);

endmodule
`default_nettype wire
